// File: src/irpwd_pkg.sv
// ----------------------------------------------------------------------------
// irpwd_pkg: shared types and constants of the IR pulse-width decoder
// Queue item layout, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package irpwd_pkg;

	localparam int TIME_W    = 32;
	localparam int THR_W     = 16;
	localparam int GAP_W     = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	// pin_level plus timestamp, padded to whole bytes
	localparam int IN_DATA_W = 40;

	// What the front end decided an accepted transfer is.
	typedef enum logic [1:0] {
		OP_RISE = 2'd0,
		OP_FALL = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_THR     = 2'd0,
		REG_ZERO_THR    = 2'd1,
		REG_START_THR   = 2'd2,
		REG_GAP_TIMEOUT = 2'd3
	} reg_idx_t;

	localparam logic [THR_W-1:0] ONE_THR_RST   = 16'd1500;
	localparam logic [THR_W-1:0] ZERO_THR_RST  = 16'd450;
	localparam logic [THR_W-1:0] START_THR_RST = 16'd4000;
	localparam logic [GAP_W-1:0] GAP_RST       = 20'd100000;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] edge_time;
	} item_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// File: src/irpwd_front.sv
// ----------------------------------------------------------------------------
// irpwd_front: input stage and item queue
// Classifies each accepted transfer and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module irpwd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [irpwd_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [0:0]                       s_tuser,
	output irpwd_pkg::head_t                 head,
	input  logic                             pop
);

	irpwd_pkg::item_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	irpwd_pkg::item_t new_item;

	assign s_tready = (fill_q != 2'd2);
	assign push     = s_tvalid && s_tready;

	always_comb begin
		if (s_tuser[0]) begin
			new_item.op = irpwd_pkg::OP_READ;
		end else if (s_tdata[0]) begin
			new_item.op = irpwd_pkg::OP_RISE;
		end else begin
			new_item.op = irpwd_pkg::OP_FALL;
		end
		new_item.edge_time = s_tdata[irpwd_pkg::TIME_W:1];
	end

	assign head.valid = (fill_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// File: src/irpwd_core.sv
// ----------------------------------------------------------------------------
// irpwd_core: frame decoder and result register
// Executes one queued item per cycle against the frame state; a read waits while the result register is full.
// ----------------------------------------------------------------------------
module irpwd_core #(
	parameter int FRAME_PULSES = 32,
	parameter int KEPT_BITS    = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irpwd_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [irpwd_pkg::CFG_W-1:0]      cfg_wdata,
	input  irpwd_pkg::head_t                 head,
	output logic                             pop,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [KEPT_BITS-1:0]             key_code,
	output logic                             code_valid
);

	localparam int CNT_W = $clog2(FRAME_PULSES + 1);
	localparam logic [CNT_W-1:0] PREFIX_CNT = CNT_W'(FRAME_PULSES - KEPT_BITS);
	localparam logic [CNT_W-1:0] FRAME_CNT  = CNT_W'(FRAME_PULSES);

	logic [irpwd_pkg::THR_W-1:0]  one_thr_q, zero_thr_q, start_thr_q;
	logic [irpwd_pkg::GAP_W-1:0]  gap_q;

	logic                         ready_q, ready_d;
	logic                         in_frame_q, in_frame_d;
	logic [CNT_W-1:0]             cnt_q, cnt_d;
	logic [irpwd_pkg::TIME_W-1:0] last_q, last_d;
	logic [KEPT_BITS-1:0]         accum_q, accum_d;
	logic [KEPT_BITS-1:0]         weight_q, weight_d;

	logic                         m_tvalid_q;
	logic [KEPT_BITS-1:0]         key_q;
	logic                         valid_bit_q;

	logic                         out_free;
	logic                         is_read;
	logic                         level;
	logic [irpwd_pkg::TIME_W-1:0] t;
	logic [irpwd_pkg::TIME_W-1:0] len;

	assign out_free = !m_tvalid_q || m_tready;
	assign is_read  = (head.item.op == irpwd_pkg::OP_READ);
	assign level    = (head.item.op == irpwd_pkg::OP_RISE);
	assign t        = head.item.edge_time;
	assign len      = t - last_q;
	// Edges never wait on the output; a read needs a free result register.
	assign pop      = head.valid && (!is_read || out_free);

	always_comb begin
		ready_d    = ready_q;
		in_frame_d = in_frame_q;
		cnt_d      = cnt_q;
		last_d     = last_q;
		accum_d    = accum_q;
		weight_d   = weight_q;
		if (pop && is_read) begin
			if (ready_q) begin
				ready_d = 1'b0;
				cnt_d   = '0;
			end
		end else if (pop && !ready_q) begin
			if (!in_frame_q) begin
				if (!(cnt_q == '0 && level)) begin
					in_frame_d = 1'b1;
				end
				last_d = t;
			end else if (last_q > t) begin
				cnt_d  = '0;
				last_d = t;
			end else if (len > irpwd_pkg::TIME_W'(gap_q)) begin
				in_frame_d = 1'b0;
				cnt_d      = '0;
				last_d     = t;
			end else if (level) begin
				last_d = t;
			end else begin
				last_d = t;
				if (len < irpwd_pkg::TIME_W'(start_thr_q)) begin
					if (cnt_q < PREFIX_CNT) begin
						weight_d = KEPT_BITS'(1);
						accum_d  = '0;
						cnt_d    = cnt_q + CNT_W'(1);
					end else if (len <= irpwd_pkg::TIME_W'(zero_thr_q)) begin
						in_frame_d = 1'b0;
						cnt_d      = '0;
					end else begin
						if (len > irpwd_pkg::TIME_W'(one_thr_q)) begin
							accum_d = accum_q | weight_q;
						end
						weight_d = weight_q << 1;
						cnt_d    = cnt_q + CNT_W'(1);
					end
				end
				if (cnt_d >= FRAME_CNT) begin
					ready_d    = 1'b1;
					in_frame_d = 1'b0;
					cnt_d      = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_thr_q   <= irpwd_pkg::ONE_THR_RST;
			zero_thr_q  <= irpwd_pkg::ZERO_THR_RST;
			start_thr_q <= irpwd_pkg::START_THR_RST;
			gap_q       <= irpwd_pkg::GAP_RST;
			ready_q     <= 1'b0;
			in_frame_q  <= 1'b0;
			cnt_q       <= '0;
			last_q      <= '0;
			accum_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					irpwd_pkg::REG_ONE_THR:     one_thr_q   <= cfg_wdata[irpwd_pkg::THR_W-1:0];
					irpwd_pkg::REG_ZERO_THR:    zero_thr_q  <= cfg_wdata[irpwd_pkg::THR_W-1:0];
					irpwd_pkg::REG_START_THR:   start_thr_q <= cfg_wdata[irpwd_pkg::THR_W-1:0];
					irpwd_pkg::REG_GAP_TIMEOUT: gap_q       <= cfg_wdata;
				endcase
			end
			ready_q    <= ready_d;
			in_frame_q <= in_frame_d;
			cnt_q      <= cnt_d;
			last_q     <= last_d;
			accum_q    <= accum_d;
			if (pop && is_read) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Bit weight has no reset: every frame sets it before the kept pulses.
	always_ff @(posedge clk) begin
		weight_q <= weight_d;
		if (pop && is_read) begin
			key_q       <= ready_q ? accum_q : '0;
			valid_bit_q <= ready_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign key_code   = key_q;
	assign code_valid = valid_bit_q;

endmodule

// File: src/ir_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder: pulse-width decoder for remote-control frames
// Decodes edge timestamps into a code that is held until read.
// ----------------------------------------------------------------------------
// Read path: an accepted read transfer is first written into the queue; the
// decoder then pops it and loads the result register, which raises m_tvalid.
// Throughput: one transfer per cycle while the queue has room; the decoder
// retires each item as it pops it, and only a read waits, for a free result
// register, so a stalled read lets the queue fill and s_tready drop.
// Reset: arst_n clears the queue, the result valid and all frame state but
// the bit weight; it loads the threshold defaults at once, no clearing pass.
module ir_pulse_width_decoder #(
	parameter int FRAME_PULSES = 32,
	parameter int KEPT_BITS    = 15,
	localparam int OUT_W       = ((KEPT_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream. s_tdata from bit 0: pin_level, edge_time_us[31:0], zero pad.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [irpwd_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser from bit 0: cmd (0 pin edge, 1 read request).
	input  logic [0:0]                       s_tuser,
	// Result stream. m_tdata from bit 0: key_code, zero pad.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,
	// m_tuser from bit 0: code_valid.
	output logic [0:0]                       m_tuser,
	// Register write port: index 0 one threshold, 1 zero threshold,
	// 2 start threshold, 3 gap timeout.
	input  logic                             cfg_we,
	input  logic [irpwd_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [irpwd_pkg::CFG_W-1:0]      cfg_wdata
);

	irpwd_pkg::head_t     head;
	logic                 pop;
	logic [KEPT_BITS-1:0] key_code;
	logic                 code_valid;

	// The front end turns each transfer into a rising edge, a falling edge or
	// a read, and queues it; while a result stalls, edges keep flowing but a read waits.
	irpwd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	// The back end measures pulses, builds the code and answers reads.
	irpwd_core #(
		.FRAME_PULSES (FRAME_PULSES),
		.KEPT_BITS    (KEPT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.pop        (pop),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.key_code   (key_code),
		.code_valid (code_valid)
	);

	assign m_tdata    = OUT_W'(key_code);
	assign m_tuser[0] = code_valid;

endmodule

// File: src/irpwd_checker.sv
// ----------------------------------------------------------------------------
// irpwd_checker: port-level checks for the IR pulse-width decoder
// Watches the result stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module irpwd_checker #(
	parameter int KEPT_BITS = 15,
	localparam int OUT_W    = ((KEPT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [0:0]       m_tuser
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// A read with no code ready returns an all-zero code.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("nonzero code without code_valid");

	// Nothing is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind ir_pulse_width_decoder irpwd_checker #(
	.KEPT_BITS (KEPT_BITS)
) u_irpwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/ir_pulse_width_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_tb: self-checking bench of the IR pulse-width decoder
// Edge and read transfers go in with random gaps while the result side stalls
// at random. A behavioral decoder in the bench predicts every read result but
// the directed ones, which carry their own; each is checked field by field.
// ----------------------------------------------------------------------------
module ir_pulse_width_decoder_tb;

	localparam int FRAME_PULSES = 32;
	localparam int KEPT_BITS    = 15;
	localparam int PREFIX       = FRAME_PULSES - KEPT_BITS;
	localparam int LIMIT        = 1000000;
	// Wait that drain() adds once no expected result is left.
	localparam int SETTLE       = 8;

	// s_tuser values.
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic [14:0] key;
		logic        valid;
	} code_t;

	// One row of the directed table; a typed row carries its own expected read.
	typedef struct packed {
		logic        cmd;
		logic        level;
		logic [31:0] t;
		logic        typed;
		logic [14:0] key;
		logic        valid;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [irpwd_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [0:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [15:0]                     m_tdata;
	logic [0:0]                      m_tuser;
	logic                            cfg_we = 1'b0;
	logic [irpwd_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [irpwd_pkg::CFG_W-1:0]     cfg_wdata = '0;

	ir_pulse_width_decoder #(
		.FRAME_PULSES(FRAME_PULSES),
		.KEPT_BITS   (KEPT_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Bench copy of the register file.
	logic [15:0] thr_one, thr_zero, thr_start;
	logic [19:0] gap_limit;

	// Bench copy of the decoder state.
	logic        dec_ready, dec_in_frame;
	logic [5:0]  dec_count;
	logic [31:0] dec_last;
	logic [14:0] dec_accum;
	logic [31:0] dec_weight;

	code_t       code_q[$];
	int          n_fail = 0;
	int          n_items = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	int          rx_hold = 0;
	logic [31:0] now_us;

	// Follows one pin edge. Falling edges close a pulse measured from the
	// previous edge of either kind.
	function automatic void decode_edge(logic level, logic [31:0] t);
		logic [31:0] len;
		if (dec_ready)
			return;
		if (!dec_in_frame) begin
			// A high edge with nothing counted leaves the decoder idle.
			if (!(dec_count == 0 && level))
				dec_in_frame = 1'b1;
			dec_last = t;
			return;
		end
		// The clock went backwards or wrapped: restart the count, keep the frame.
		if (dec_last > t) begin
			dec_count = '0;
			dec_last = t;
			return;
		end
		len = t - dec_last;
		if (len > gap_limit) begin
			dec_in_frame = 1'b0;
			dec_count = '0;
			dec_last = t;
			return;
		end
		if (level) begin
			dec_last = t;
			return;
		end
		if (len < thr_start) begin
			if (dec_count < PREFIX) begin
				dec_weight = 32'd1;
				dec_accum = '0;
			end else begin
				// A too short data pulse kills the frame and is not counted.
				if (len <= thr_zero) begin
					dec_in_frame = 1'b0;
					dec_count = '0;
					dec_last = t;
					return;
				end
				if (len > thr_one)
					dec_accum = dec_accum | dec_weight[14:0];
				dec_weight = dec_weight << 1;
			end
			dec_count = dec_count + 6'd1;
		end
		if (dec_count >= FRAME_PULSES) begin
			dec_ready = 1'b1;
			dec_in_frame = 1'b0;
			dec_count = '0;
		end
		dec_last = t;
	endfunction

	// A read hands out the waiting code once and clears it.
	function automatic code_t decode_read();
		code_t r;
		r = '0;
		if (dec_ready) begin
			r.key = dec_accum;
			r.valid = 1'b1;
			dec_ready = 1'b0;
			dec_count = '0;
		end
		return r;
	endfunction

	// Random idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (quiet || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Uniform pick in [lo, hi]; an empty range collapses to lo.
	function automatic logic [31:0] pick(longint lo, longint hi);
		if (lo < 0)
			lo = 0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		if (hi < lo)
			return lo[31:0];
		return $urandom_range(hi[31:0], lo[31:0]);
	endfunction

	function automatic logic [31:0] within_gap(logic [31:0] x);
		return (x > gap_limit) ? {12'd0, gap_limit} : x;
	endfunction

	// Offers one transfer and holds it until the decoder takes it. The result
	// of a read is predicted at the edge that accepts it.
	task automatic send_item(logic cmd, logic level, logic [31:0] t, logic typed,
			code_t typed_code);
		int gap;
		code_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, t, level};
		do @(posedge clk); while (!s_tready);
		n_items++;
		if (cmd == CMD_READ) begin
			r = decode_read();
			code_q.push_back(typed ? typed_code : r);
		end else begin
			decode_edge(level, t);
		end
	endtask

	task automatic send_edge(logic level, logic [31:0] t);
		send_item(CMD_EDGE, level, t, 1'b0, '0);
	endtask

	task automatic send_read();
		// Pin level and timestamp are don't-care on a read; fill them at random.
		send_item(CMD_READ, 1'($urandom), $urandom, 1'b0, '0);
	endtask

	// Stops the input stream and lets every expected result drain out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles; only called when idle.
	task automatic set_regs(logic [15:0] one, logic [15:0] zero, logic [15:0] start,
			logic [19:0] gap);
		cfg_we <= 1'b1;
		cfg_addr <= irpwd_pkg::REG_ONE_THR;
		cfg_wdata <= {4'd0, one};
		@(posedge clk);
		thr_one = one;
		cfg_addr <= irpwd_pkg::REG_ZERO_THR;
		cfg_wdata <= {4'd0, zero};
		@(posedge clk);
		thr_zero = zero;
		cfg_addr <= irpwd_pkg::REG_START_THR;
		cfg_wdata <= {4'd0, start};
		@(posedge clk);
		thr_start = start;
		cfg_addr <= irpwd_pkg::REG_GAP_TIMEOUT;
		cfg_wdata <= gap;
		@(posedge clk);
		gap_limit = gap;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one frame shaped after the current thresholds, then reads it.
	// Most frames are clean; some carry one defect at a random pulse, some get extra edges before the read.
	task automatic run_frame();
		int variant;
		int bad_at;
		int i;
		logic [31:0] len;
		variant = $urandom_range(99, 0);
		bad_at = $urandom_range(FRAME_PULSES - 1, 0);
		// A gap past the timeout closes whatever was open, then open afresh.
		now_us = now_us + gap_limit + 1 + $urandom_range(50, 0);
		send_edge(1'b0, now_us);
		// Leader pulse, long enough to be skipped.
		now_us = now_us + within_gap(pick(100, 9000));
		send_edge(1'b1, now_us);
		now_us = now_us + within_gap(pick(thr_start, longint'(thr_start) + 500));
		send_edge(1'b0, now_us);
		for (i = 0; i < FRAME_PULSES; i++) begin
			now_us = now_us + within_gap(pick(100, 600));
			send_edge(1'b1, now_us);
			if ($urandom_range(19, 0) == 0) begin
				// A stray long pulse between data pulses.
				now_us = now_us + within_gap(pick(thr_start, longint'(thr_start) + 3000));
				send_edge(1'b0, now_us);
				now_us = now_us + within_gap(pick(100, 600));
				send_edge(1'b1, now_us);
			end
			if (i < PREFIX)
				len = within_gap(pick(1, longint'(thr_start) - 1));
			else if ($urandom_range(1, 0))
				len = within_gap(pick(longint'(thr_one) + 1, longint'(thr_start) - 1));
			else
				len = within_gap(pick(longint'(thr_zero) + 1, thr_one));
			if (i == bad_at) begin
				if (variant >= 70 && variant < 80)
					len = pick(0, thr_zero);
				else if (variant >= 80 && variant < 87)
					len = gap_limit + 1 + $urandom_range(1000, 0);
			end
			if (i == bad_at && variant >= 87 && variant < 93)
				now_us = now_us - $urandom_range(1000, 1);
			else
				now_us = now_us + len;
			send_edge(1'b0, now_us);
		end
		// Edges while a code waits must not disturb it.
		if (variant >= 93) begin
			repeat ($urandom_range(6, 1)) begin
				now_us = now_us + $urandom_range(2000, 1);
				send_edge(1'($urandom), now_us);
			end
		end
		send_read();
	endtask

	// Unstructured traffic: random levels, jumps and reads.
	task automatic run_noise(int n);
		repeat (n) begin
			if ($urandom_range(9, 0) < 3) begin
				send_read();
			end else begin
				if ($urandom_range(1, 0))
					now_us = $urandom;
				else
					now_us = now_us + $urandom_range(5000, 0);
				send_edge(1'($urandom), now_us);
			end
		end
	endtask

	// The directed rows: reads after reset, timestamp extremes and wrap, a
	// skipped long pulse, a short pulse in the prefix, gap timeouts.
	dir_row_t dir_tab [19] = '{
		'{CMD_READ, 1'b0, 32'h0000_0000, 1'b1, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'h0000_0005, 1'b0, 15'd0, 1'b0},
		'{CMD_READ, 1'b0, 32'h0000_0000, 1'b1, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'hFFFF_FFF0, 1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'hFFFF_FFFF, 1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'h0000_0000, 1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'd560,       1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'd1120,      1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'd1680,      1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'd10680,     1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'd11240,     1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'd11440,     1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b1, 32'd211440,    1'b0, 15'd0, 1'b0},
		'{CMD_READ, 1'b0, 32'h0000_0000, 1'b1, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'h7FFF_FFFF, 1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'h8001_86A1, 1'b0, 15'd0, 1'b0},
		'{CMD_EDGE, 1'b0, 32'h0000_0000, 1'b0, 15'd0, 1'b0},
		'{CMD_READ, 1'b0, 32'h0000_0000, 1'b1, 15'd0, 1'b0},
		'{CMD_READ, 1'b1, 32'hFFFF_FFFF, 1'b1, 15'd0, 1'b0}
	};

	// Stimulus and end of run.
	initial begin
		int phase;
		int i;
		logic [15:0] z;
		logic [15:0] o;
		logic [15:0] s;
		// Driven after time zero settles so the reset edge is seen.
		arst_n <= 1'b0;
		thr_one = irpwd_pkg::ONE_THR_RST;
		thr_zero = irpwd_pkg::ZERO_THR_RST;
		thr_start = irpwd_pkg::START_THR_RST;
		gap_limit = irpwd_pkg::GAP_RST;
		dec_ready = 1'b0;
		dec_in_frame = 1'b0;
		dec_count = '0;
		dec_last = '0;
		dec_accum = '0;
		dec_weight = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_tab); i++)
			send_item(dir_tab[i].cmd, dir_tab[i].level, dir_tab[i].t, dir_tab[i].typed,
				'{dir_tab[i].key, dir_tab[i].valid});

		phase = 0;
		now_us = $urandom;
		while (n_items < 900 && phase < 60) begin
			// Registers change only between phases, with the decoder idle.
			if (phase > 0) begin
				drain();
				case (phase)
					1: set_regs(16'd0, 16'd0, 16'hFFFF, 20'hFFFFF);
					2: set_regs(16'hFFFF, 16'hFFFF, 16'd0, 20'd0);
					3: set_regs(16'hFFFF, 16'd0, 16'hFFFF, 20'hFFFFF);
					4: set_regs(irpwd_pkg::ONE_THR_RST, irpwd_pkg::ZERO_THR_RST,
						irpwd_pkg::START_THR_RST, irpwd_pkg::GAP_RST);
					default: begin
						z = 16'($urandom_range(800, 100));
						o = 16'(z + $urandom_range(1500, 200));
						s = 16'(o + $urandom_range(3000, 500));
						set_regs(o, z, s, 20'(pick(longint'(s) + 5000, 20'hFFFFF)));
					end
				endcase
				now_us = $urandom;
			end
			quiet = (phase % 4 == 3);
			repeat ($urandom_range(4, 2)) begin
				run_noise($urandom_range(12, 0));
				run_frame();
			end
			phase++;
		end

		drain();
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// The result side stalls at random, with the same gap profile as the input.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			rx_hold <= pick_gap();
		end
	end

	// Each result transfer is checked against the oldest predicted read.
	always @(posedge clk) begin : result_check
		code_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (code_q.size() == 0) begin
				$error("result transfer with no read waiting: key_code %h code_valid %b",
					m_tdata[14:0], m_tuser[0]);
				n_fail++;
			end else begin
				want = code_q.pop_front();
				if (m_tdata[14:0] !== want.key) begin
					$error("key_code mismatch: expected %h, got %h", want.key, m_tdata[14:0]);
					n_fail++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("code_valid mismatch: expected %b, got %b", want.valid, m_tuser[0]);
					n_fail++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// File: files.f
src/irpwd_pkg.sv
src/irpwd_front.sv
src/irpwd_core.sv
src/ir_pulse_width_decoder.sv
src/irpwd_checker.sv
tb/ir_pulse_width_decoder_tb.sv
